/* design/dccu_pkg.sv */
// dccu_pkg: shared types, constants and calendar tables for the day count unit
// no dependencies; used by dccu_date_term and day_count_convention_unit
package dccu_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 23;
    localparam int SERIAL_W = 23;

    // convention codes
    localparam logic [2:0] CONV_ACT360  = 3'd0;
    localparam logic [2:0] CONV_ACT365  = 3'd1;
    localparam logic [2:0] CONV_US      = 3'd2;
    localparam logic [2:0] CONV_EURO    = 3'd3;
    localparam logic [2:0] CONV_ITALIAN = 3'd4;
    localparam logic [2:0] CONV_GERMAN  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_CONVENTION  = 2'd0;
    localparam logic [1:0] REG_INCLUDE_DAY = 2'd1;
    localparam logic [1:0] REG_LAST_PERIOD = 2'd2;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 2^15
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam int          PROD_W      = 28;

    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic [SERIAL_W-1:0] noleap;
        logic                leap;
    } date_terms_t;

    function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        if (m == 4'd0)
            r = 4'd1;
        else if (m > 4'd12)
            r = 4'd12;
        else
            r = m;
        return r;
    endfunction

    // days before the first of month m in a year with no leap day
    function automatic logic [8:0] jan_offset(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            default: r = 9'd334;
        endcase
        return r;
    endfunction

    // days before a month counted from march, (153 * mp + 2) / 5
    function automatic logic [8:0] mar_offset(input logic [MONTH_W-1:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            default: r = 9'd337;
        endcase
        return r;
    endfunction

endpackage

/* design/dccu_date_term.sv */
// dccu_date_term: two pipeline stages that turn one date into its serial day
// number, its no-leap day number and its leap year flag; depends on dccu_pkg
module dccu_date_term (
    input  logic                               clk,
    input  logic                               en_a,
    input  logic                               en_b,
    input  logic [dccu_pkg::YEAR_W-1:0]        year,
    input  logic [dccu_pkg::MONTH_W-1:0]       month,
    input  logic [dccu_pkg::DAY_W-1:0]         day,
    output dccu_pkg::date_terms_t              terms
);

    localparam int YY_W = dccu_pkg::YEAR_W + 1;
    localparam int Q_HI = dccu_pkg::RECIP_SHIFT + 7;

    // stage a
    logic [dccu_pkg::MONTH_W-1:0]  mc;
    logic                          early;
    logic [YY_W-1:0]               yy;
    logic [dccu_pkg::MONTH_W-1:0]  mp;
    logic [dccu_pkg::PROD_W-1:0]   pyy;
    logic [dccu_pkg::PROD_W-1:0]   py;
    logic [dccu_pkg::SERIAL_W-1:0] y365;
    logic                          feb29;
    logic [dccu_pkg::SERIAL_W-1:0] noleap_next;

    logic [YY_W-1:0]               yy_reg;
    logic [dccu_pkg::MONTH_W-1:0]  mp_reg;
    logic [dccu_pkg::DAY_W-1:0]    day_reg;
    logic [7:0]                    qyy_reg;
    logic [7:0]                    qy_reg;
    logic [dccu_pkg::YEAR_W-1:0]   year_reg;
    logic [dccu_pkg::SERIAL_W-1:0] noleap_reg;

    // stage b
    logic [dccu_pkg::SERIAL_W:0]   serial_sum;
    logic [dccu_pkg::YEAR_W-1:0]   hundred;
    logic                          leap;
    dccu_pkg::date_terms_t         terms_next;
    dccu_pkg::date_terms_t         terms_reg;

    assign mc    = dccu_pkg::clamp_month(month);
    assign early = (mc <= 4'd2);
    assign yy    = YY_W'(year) + YY_W'(400) - YY_W'(early);
    assign mp    = early ? (mc + 4'd9) : (mc - 4'd3);
    assign pyy   = dccu_pkg::PROD_W'(yy) * dccu_pkg::PROD_W'(dccu_pkg::RECIP_100);
    assign py    = dccu_pkg::PROD_W'(year) * dccu_pkg::PROD_W'(dccu_pkg::RECIP_100);
    assign y365  = dccu_pkg::SERIAL_W'(year) * dccu_pkg::SERIAL_W'(365);
    assign feb29 = (month == 4'd2) && (day == 5'd29);

    // feb 29 counts as feb 28
    assign noleap_next = y365 + dccu_pkg::SERIAL_W'(dccu_pkg::jan_offset(mc))
                       + dccu_pkg::SERIAL_W'(day) - dccu_pkg::SERIAL_W'(feb29);

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            yy_reg     <= yy;
            mp_reg     <= mp;
            day_reg    <= day;
            qyy_reg    <= pyy[Q_HI:dccu_pkg::RECIP_SHIFT];
            qy_reg     <= py[Q_HI:dccu_pkg::RECIP_SHIFT];
            year_reg   <= year;
            noleap_reg <= noleap_next;
        end
    end

    // 365*yy + yy/4 - yy/100 + yy/400 + march offset + day - 1
    assign serial_sum = (dccu_pkg::SERIAL_W+1)'(yy_reg) * (dccu_pkg::SERIAL_W+1)'(365)
                      + (dccu_pkg::SERIAL_W+1)'(yy_reg[YY_W-1:2])
                      - (dccu_pkg::SERIAL_W+1)'(qyy_reg)
                      + (dccu_pkg::SERIAL_W+1)'(qyy_reg[7:2])
                      + (dccu_pkg::SERIAL_W+1)'(dccu_pkg::mar_offset(mp_reg))
                      + (dccu_pkg::SERIAL_W+1)'(day_reg)
                      - (dccu_pkg::SERIAL_W+1)'(1);

    assign hundred = dccu_pkg::YEAR_W'(qy_reg) * dccu_pkg::YEAR_W'(100);
    assign leap    = (year_reg[1:0] == 2'd0)
                   && ((year_reg != hundred) || (qy_reg[1:0] == 2'd0));

    always_comb
    begin
        terms_next.serial = serial_sum[dccu_pkg::SERIAL_W-1:0];
        terms_next.noleap = noleap_reg;
        terms_next.leap   = leap;
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
            terms_reg <= terms_next;
    end

    assign terms = terms_reg;

endmodule

/* design/day_count_convention_unit.sv */
// day_count_convention_unit: signed day count between two dates, six conventions
// pipeline: three register stages, a, b and c; out_valid is the valid bit of stage c
// throughput: one transaction per cycle; a stall at the output holds the stages that are full
// reset: rst_n clears the stage valid bits and the three configuration registers
// depends on dccu_pkg and dccu_date_term
module day_count_convention_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_addr,
    input  logic [2:0]                           cfg_wdata,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dccu_pkg::YEAR_W-1:0]          start_year,
    input  logic [dccu_pkg::MONTH_W-1:0]         start_month,
    input  logic [dccu_pkg::DAY_W-1:0]           start_day,
    input  logic [dccu_pkg::YEAR_W-1:0]          end_year,
    input  logic [dccu_pkg::MONTH_W-1:0]         end_month,
    input  logic [dccu_pkg::DAY_W-1:0]           end_day,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dccu_pkg::COUNT_W-1:0]  day_count
);

    // working width of the signed sums before saturation
    localparam int SUM_W = dccu_pkg::COUNT_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (dccu_pkg::COUNT_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(2 ** (dccu_pkg::COUNT_W - 1));
    localparam int DY_W = dccu_pkg::YEAR_W + 1;
    localparam int DM_W = dccu_pkg::MONTH_W + 2;

    // configuration registers
    logic [2:0] convention_reg;
    logic       include_day_reg;
    logic       last_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            convention_reg  <= dccu_pkg::CONV_ACT360;
            include_day_reg <= 1'b0;
            last_period_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dccu_pkg::REG_CONVENTION:  convention_reg  <= cfg_wdata;
                dccu_pkg::REG_INCLUDE_DAY: include_day_reg <= cfg_wdata[0];
                dccu_pkg::REG_LAST_PERIOD: last_period_reg <= cfg_wdata[0];
                default:                   ;
            endcase
        end
    end

    // pipeline control: each stage moves when the one after it is free or moving
    logic va_reg, vb_reg, vc_reg;
    logic en_a, en_b, en_c;

    assign en_c     = !vc_reg || out_ready;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                va_reg <= in_valid;
            if (en_b)
                vb_reg <= va_reg;
            if (en_c)
                vc_reg <= vb_reg;
        end
    end

    // per-date serial and no-leap day numbers, stages a and b
    dccu_pkg::date_terms_t terms_start;
    dccu_pkg::date_terms_t terms_end;

    dccu_date_term u_start_term (
        .clk   (clk),
        .en_a  (en_a),
        .en_b  (en_b),
        .year  (start_year),
        .month (start_month),
        .day   (start_day),
        .terms (terms_start)
    );

    dccu_date_term u_end_term (
        .clk   (clk),
        .en_a  (en_a),
        .en_b  (en_b),
        .year  (end_year),
        .month (end_month),
        .day   (end_day),
        .terms (terms_end)
    );

    // stage a: us and italian day adjustments for the 30/360 family
    logic                         is_us, is_italian, us_roll;
    logic [dccu_pkg::DAY_W-1:0]   d1_adj, d2_adj;
    logic [dccu_pkg::MONTH_W:0]   m2_adj;

    assign is_us      = (convention_reg == dccu_pkg::CONV_US);
    assign is_italian = (convention_reg == dccu_pkg::CONV_ITALIAN);
    // end day 31 after a start day below 30 rolls to the first of the next month
    assign us_roll    = is_us && (end_day == 5'd31) && (start_day < 5'd30);

    always_comb
    begin
        d1_adj = start_day;
        d2_adj = end_day;
        if (is_italian && (start_month == 4'd2) && (start_day > 5'd27))
            d1_adj = 5'd30;
        if (us_roll)
            d2_adj = 5'd1;
        else if (is_italian && (end_month == 4'd2) && (end_day > 5'd27))
            d2_adj = 5'd30;
    end

    assign m2_adj = (dccu_pkg::MONTH_W+1)'(end_month) + (dccu_pkg::MONTH_W+1)'(us_roll);

    logic [dccu_pkg::YEAR_W-1:0]  y1_a_reg, y2_a_reg;
    logic [dccu_pkg::MONTH_W-1:0] m1_a_reg;
    logic [dccu_pkg::MONTH_W:0]   m2_a_reg;
    logic [dccu_pkg::DAY_W-1:0]   d1_a_reg, d2_a_reg;
    logic                         feb1_a_reg, feb2_a_reg;

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            y1_a_reg   <= start_year;
            y2_a_reg   <= end_year;
            m1_a_reg   <= start_month;
            m2_a_reg   <= m2_adj;
            d1_a_reg   <= d1_adj;
            d2_a_reg   <= d2_adj;
            feb1_a_reg <= (start_month == 4'd2);
            feb2_a_reg <= (end_month == 4'd2);
        end
    end

    // stage b: year and month part of 30/360, 360*dy + 30*dm with dm = m2 - m1 - 1
    logic signed [DY_W-1:0]  dy;
    logic signed [DM_W-1:0]  dm;
    logic signed [SUM_W-1:0] p30_next;

    assign dy = $signed(DY_W'(y2_a_reg)) - $signed(DY_W'(y1_a_reg));
    assign dm = $signed(DM_W'(m2_a_reg)) - $signed(DM_W'(m1_a_reg)) - DM_W'(1);
    assign p30_next = SUM_W'(dy) * SUM_W'(360) + SUM_W'(dm) * SUM_W'(30);

    logic signed [SUM_W-1:0]    p30_b_reg;
    logic [dccu_pkg::DAY_W-1:0] d1_b_reg, d2_b_reg;
    logic                       feb1_b_reg, feb2_b_reg;

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            p30_b_reg  <= p30_next;
            d1_b_reg   <= d1_a_reg;
            d2_b_reg   <= d2_a_reg;
            feb1_b_reg <= feb1_a_reg;
            feb2_b_reg <= feb2_a_reg;
        end
    end

    // stage c: german last-of-february rule, day clamps, selection, saturation
    logic                       is_german;
    logic [dccu_pkg::DAY_W-1:0] d1_g, d2_g;
    logic [dccu_pkg::DAY_W-1:0] a_term, b_term;
    logic signed [SUM_W-1:0]    r30, r_act360, r_act365, r_sel, r_sat;

    assign is_german = (convention_reg == dccu_pkg::CONV_GERMAN);

    always_comb
    begin
        d1_g = d1_b_reg;
        d2_g = d2_b_reg;
        // last day of february is day 28, or 29 in a leap year
        if (is_german && feb1_b_reg && (d1_b_reg == 5'd28 + 5'(terms_start.leap)))
            d1_g = 5'd30;
        if (is_german && !last_period_reg && feb2_b_reg
            && (d2_b_reg == 5'd28 + 5'(terms_end.leap)))
            d2_g = 5'd30;
    end

    assign a_term = (d1_g >= 5'd30) ? 5'd0 : (5'd30 - d1_g);
    assign b_term = (d2_g > 5'd30) ? 5'd30 : d2_g;
    assign r30    = p30_b_reg + SUM_W'(a_term) + SUM_W'(b_term);

    assign r_act360 = $signed(SUM_W'(terms_end.serial)) - $signed(SUM_W'(terms_start.serial))
                    + SUM_W'(include_day_reg);
    assign r_act365 = $signed(SUM_W'(terms_end.noleap)) - $signed(SUM_W'(terms_start.noleap));

    always_comb
    begin
        unique case (convention_reg)
            dccu_pkg::CONV_ACT360: r_sel = r_act360;
            dccu_pkg::CONV_ACT365: r_sel = r_act365;
            dccu_pkg::CONV_US,
            dccu_pkg::CONV_EURO,
            dccu_pkg::CONV_ITALIAN,
            dccu_pkg::CONV_GERMAN: r_sel = r30;
            // reserved codes give zero
            default:               r_sel = '0;
        endcase
    end

    always_comb
    begin
        if (r_sel > SAT_HI)
            r_sat = SAT_HI;
        else if (r_sel < SAT_LO)
            r_sat = SAT_LO;
        else
            r_sat = r_sel;
    end

    // output register; holds while out_valid is high and out_ready is low
    logic signed [dccu_pkg::COUNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (en_c)
            count_reg <= r_sat[dccu_pkg::COUNT_W-1:0];
    end

    assign out_valid = vc_reg;
    assign day_count = count_reg;

endmodule
